>>> rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants for the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam int HEADER_BYTES        = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  // result kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // item kinds
  localparam logic FUNC_BYTE       = 1'b0;
  localparam logic FUNC_DISCONNECT = 1'b1;

  // one command from the front to the back: a single result word, or a
  // header burst that the back expands into HEADER_BYTES result words
  typedef struct packed {
    logic                         burst;
    logic                         kind;
    logic [7:0]                   data;
    logic                         last;
    logic [HEADER_BYTES-1:0][7:0] hdr;
  } cmd_t;

endpackage

>>> rtl/lppd_front.sv
// ----------------------------------------------------------------------------
// lppd_front
// Accepts stream bytes and disconnects, collects the header, checks the
// length and issues result commands into the command queue.
// ----------------------------------------------------------------------------
module lppd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 func,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          max_packet_len,
  output logic                 cmd_push,
  output lppd_pkg::cmd_t       cmd
);
  import lppd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DROP   = 2'd2
  } phase_t;

  phase_t                       phase;
  phase_t                       phase_next;
  logic [15:0]                  byte_position;
  logic [15:0]                  byte_position_next;
  logic [15:0]                  packet_length;
  logic [15:0]                  packet_length_next;
  logic [HEADER_BYTES-1:0][7:0] header_store;
  logic [HEADER_BYTES-1:0][7:0] hdr_full;
  logic [15:0]                  len_low;
  logic [15:0]                  pos_inc;
  logic                         len_bad;
  logic                         hdr_done;

  // header as it stands once the current byte is placed at the end
  always_comb begin
    hdr_full                   = header_store;
    hdr_full[HEADER_BYTES-1]   = rx_byte;
  end

  assign len_low  = {header_store[2], header_store[3]};
  assign len_bad  = ((header_store[0] | header_store[1]) != 8'd0)
                    || (len_low < 16'(HEADER_BYTES))
                    || (len_low > max_packet_len);
  assign pos_inc  = byte_position + 16'd1;
  assign hdr_done = (byte_position == 16'(HEADER_BYTES - 1));

  // classify the item and build its command
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    packet_length_next = packet_length;
    cmd_push           = 1'b0;
    cmd                = '0;
    if (accept) begin
      if (func == FUNC_DISCONNECT) begin
        phase_next         = PH_HEADER;
        byte_position_next = '0;
        packet_length_next = '0;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            byte_position_next = pos_inc;
            if (hdr_done) begin
              cmd_push = 1'b1;
              if (len_bad) begin
                phase_next         = PH_DROP;
                byte_position_next = '0;
                cmd.kind           = KIND_ERROR;
                cmd.last           = 1'b1;
              end else begin
                cmd.burst = 1'b1;
                cmd.kind  = KIND_BYTE;
                cmd.hdr   = hdr_full;
                cmd.last  = (len_low == 16'(HEADER_BYTES));
                if (len_low == 16'(HEADER_BYTES)) begin
                  byte_position_next = '0;
                end else begin
                  phase_next         = PH_BODY;
                  packet_length_next = len_low;
                  byte_position_next = 16'(HEADER_BYTES);
                end
              end
            end
          end
          PH_BODY: begin
            cmd_push           = 1'b1;
            cmd.kind           = KIND_BYTE;
            cmd.data           = rx_byte;
            cmd.last           = (pos_inc >= packet_length);
            byte_position_next = pos_inc;
            if (pos_inc >= packet_length) begin
              phase_next         = PH_HEADER;
              byte_position_next = '0;
              packet_length_next = '0;
            end
          end
          default: begin
            // drop everything until a disconnect
          end
        endcase
      end
    end
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_position <= '0;
      packet_length <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      packet_length <= packet_length_next;
    end
  end

  // store header bytes as they arrive
  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_BYTE) && (phase == PH_HEADER)) begin
      header_store[byte_position[$clog2(HEADER_BYTES)-1:0]] <= rx_byte;
    end
  end

endmodule

>>> rtl/lppd_queue.sv
// ----------------------------------------------------------------------------
// lppd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module lppd_queue #(
  parameter int DEPTH = lppd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  lppd_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output lppd_pkg::cmd_t rd_data,
  output logic           full,
  output logic           nempty
);
  import lppd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          store [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign nempty  = (count != '0);
  assign rd_data = store[rptr];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= ptr_inc(wptr);
      end
      if (rd_en) begin
        rptr <= ptr_inc(rptr);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // hold entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wptr] <= wr_data;
    end
  end

endmodule

>>> rtl/lppd_back.sv
// ----------------------------------------------------------------------------
// lppd_back
// Takes commands from the queue and presents result words, expanding a
// header burst into one word per header byte.
// ----------------------------------------------------------------------------
module lppd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nempty,
  input  lppd_pkg::cmd_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic           kind,
  output logic [7:0]     tx_byte,
  output logic           last
);
  import lppd_pkg::*;

  localparam int IW = $clog2(HEADER_BYTES);

  cmd_t          cur;
  logic          cur_valid;
  logic [IW-1:0] idx;
  logic          idx_end;
  logic          taken;
  logic          finish;

  assign idx_end = (idx == IW'(HEADER_BYTES - 1));
  assign taken   = pop && cur_valid;
  assign finish  = taken && (!cur.burst || idx_end);
  assign q_pop   = q_nempty && (!cur_valid || finish);
  assign empty   = !cur_valid;

  // present the current word
  always_comb begin
    if (cur.burst) begin
      kind    = KIND_BYTE;
      tx_byte = cur.hdr[idx];
      last    = cur.last && idx_end;
    end else begin
      kind    = cur.kind;
      tx_byte = cur.data;
      last    = cur.last;
    end
  end

  // advance through the burst, load the next command
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (finish) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (taken) begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

endmodule

>>> rtl/length_prefixed_packet_deframer_unit.sv
// Path: an accepted byte is written into the command queue, then loaded into
//   the back's current-command register, which drives the result ports; a
//   good header shows its eight words one per cycle while pop is held high.
// Input: one item per cycle while full is low; a good header makes the back
//   present eight words, so a body that follows at full rate can fill the
//   command queue and stall the input.
// Reset: rst clears phase, counters and the queue; max_packet_len goes to 4096.
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_unit
// Deframes a length-prefixed byte stream: checks the header length and echoes
// packet bytes, or reports a malformed length and drops until disconnect.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_unit #(
  parameter int QUEUE_DEPTH = lppd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import lppd_pkg::*;

  logic [15:0] max_packet_len;
  logic        accept;
  logic        cmd_push;
  cmd_t        cmd;
  cmd_t        q_data;
  logic        q_nempty;
  logic        q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // hold the length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_packet_len <= cfg_data;
    end
  end

  lppd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .func           (func),
    .rx_byte        (rx_byte),
    .max_packet_len (max_packet_len),
    .cmd_push       (cmd_push),
    .cmd            (cmd)
  );

  lppd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .nempty  (q_nempty)
  );

  lppd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_nempty (q_nempty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .kind     (kind),
    .tx_byte  (tx_byte),
    .last     (last)
  );

endmodule

>>> rtl/lppd_checker.sv
// ----------------------------------------------------------------------------
// lppd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lppd_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       kind,
  input logic [7:0] tx_byte,
  input logic       last,
  input logic       cfg_ready
);

  // leave reset with nothing pending and room for input
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not clear after reset");

  // an error word carries a zero byte and closes the packet
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind) |-> (tx_byte == 8'd0 && last))
    else $error("malformed error result");

  // hold a waiting result until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(tx_byte) && $stable(last)))
    else $error("waiting result changed");

  // the limit register is always writable
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind length_prefixed_packet_deframer_unit lppd_checker u_lppd_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .kind      (kind),
  .tx_byte   (tx_byte),
  .last      (last),
  .cfg_ready (cfg_ready)
);

>>> bench/length_prefixed_packet_deframer_unit_tb.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_unit_tb
// Self-checking bench for the packet deframer. A behavioural predictor tracks
// header collection, body echo and the dropped state, and queues the words
// that each accepted byte or disconnect should produce. A monitor compares
// every popped word against the oldest queued one. A short directed pass is
// followed by random traffic under several length limits, with bursty input,
// patterned output stalls, one long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lppd_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int BODY_CAP      = 40;

  typedef enum logic [1:0] {
    COLLECT_HDR = 2'd0,
    IN_BODY     = 2'd1,
    DROPPING    = 2'd2
  } deframe_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } echo_word_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        full;
  logic        func      = FUNC_BYTE;
  logic [7:0]  rx_byte   = 8'd0;
  logic        empty;
  logic        pop       = 1'b0;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = 16'd0;

  // predictor state
  deframe_phase_t   phase_q;
  logic [7:0]       hdr_q [HEADER_BYTES];
  logic [15:0]      pos_q;
  logic [15:0]      pkt_len_q;
  logic [15:0]      max_len_q;
  echo_word_t       pending_words [$];

  int  items_sent    = 0;
  int  words_checked = 0;
  int  errors_seen   = 0;
  int  mismatches    = 0;
  int  settings_used = 0;
  int  cycle_count   = 0;
  int  burst_left    = 0;
  bit  sender_gaps   = 1'b1;
  bit  offering      = 1'b0;
  int  hold_req      = 0;
  int  hold_left;
  int  stall_mode;
  int  stall_left;

  length_prefixed_packet_deframer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .rx_byte   (rx_byte),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("length_prefixed_packet_deframer_unit regression: fail");
      $finish;
    end
  end

  // clear the deframer state, as on a disconnect
  function automatic void deframe_clear();
    phase_q   = COLLECT_HDR;
    pos_q     = 16'd0;
    pkt_len_q = 16'd0;
    for (int i = 0; i < HEADER_BYTES; i++) hdr_q[i] = 8'd0;
  endfunction

  // advance the predictor by one accepted item and queue the words it yields
  function automatic void deframe_predict(logic f, logic [7:0] b);
    logic [31:0] hdr_len;
    logic        fin;
    if (f == FUNC_DISCONNECT) begin
      deframe_clear();
      return;
    end
    case (phase_q)
      COLLECT_HDR: begin
        hdr_q[pos_q[2:0]] = b;
        pos_q = pos_q + 16'd1;
        if (pos_q < HEADER_BYTES) return;
        hdr_len = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};
        if (hdr_len < HEADER_BYTES || hdr_len > {16'd0, max_len_q}) begin
          phase_q = DROPPING;
          pos_q   = 16'd0;
          pending_words.push_back('{KIND_ERROR, 8'd0, 1'b1});
        end else begin
          for (int i = 0; i < HEADER_BYTES; i++)
            pending_words.push_back('{KIND_BYTE, hdr_q[i],
                                      (i == HEADER_BYTES - 1) && (hdr_len == HEADER_BYTES)});
          if (hdr_len == HEADER_BYTES) begin
            pos_q = 16'd0;
          end else begin
            phase_q   = IN_BODY;
            pkt_len_q = hdr_len[15:0];
            pos_q     = 16'(HEADER_BYTES);
          end
        end
      end
      IN_BODY: begin
        pos_q = pos_q + 16'd1;
        fin   = (pos_q >= pkt_len_q);
        pending_words.push_back('{KIND_BYTE, b, fin});
        if (fin) begin
          phase_q   = COLLECT_HDR;
          pos_q     = 16'd0;
          pkt_len_q = 16'd0;
        end
      end
      default: ;
    endcase
  endfunction

  // check each popped word against the oldest expectation
  always @(posedge clk) begin
    echo_word_t exp_w;
    if (!rst && pop && !empty) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0d tx_byte %0h last %0d", kind, tx_byte, last);
        mismatches++;
      end else begin
        exp_w = pending_words.pop_front();
        if (kind == KIND_ERROR) errors_seen++;
        if (kind !== exp_w.kind) begin
          $error("kind: expected %0d, got %0d", exp_w.kind, kind);
          mismatches++;
        end
        if (tx_byte !== exp_w.data) begin
          $error("tx_byte: expected %0h, got %0h", exp_w.data, tx_byte);
          mismatches++;
        end
        if (last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, last);
          mismatches++;
        end
      end
    end
  end

  // receiver stalls: changing patterns, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left  = 0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(40, 250);
      end else begin
        stall_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (stall_mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (cycle_count % 3) != 0;
        endcase
      end
    end
  end

  // offer one item and hold it until accepted; idle between bursts
  task automatic send_item(input logic f, input logic [7:0] b);
    int gap;
    push    <= 1'b1;
    func    <= f;
    rx_byte <= b;
    offering = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    deframe_predict(f, b);
    items_sent++;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 6);
        push <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop offering and let every expected word drain
  task automatic wait_drained();
    if (offering) begin
      push <= 1'b0;
      offering = 1'b0;
    end
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_len_q = v;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_header(input logic [31:0] len, input int n_bytes);
    for (int i = 0; i < n_bytes; i++)
      send_item(FUNC_BYTE, (i < 4) ? len[31 - 8*i -: 8] : pick_byte());
  endtask

  // one packet with a length picked around the current limit
  task automatic send_random_packet();
    logic [31:0] len;
    int          r;
    int          n_body;
    int          n_send;
    r = $urandom_range(0, 99);
    if (r < 35 && max_len_q >= HEADER_BYTES)
      len = $urandom_range(HEADER_BYTES, (max_len_q > 40) ? 40 : max_len_q);
    else if (r < 45) len = HEADER_BYTES;
    else if (r < 55) len = {16'd0, max_len_q};
    else if (r < 65) len = {16'd0, max_len_q} + 32'd1;
    else if (r < 75) len = $urandom_range(0, HEADER_BYTES - 1);
    else if (r < 85) len = {16'($urandom_range(1, 65535)), 16'($urandom())};
    else             len = $urandom();

    // broken header: part of it, then the link drops
    if ($urandom_range(0, 19) == 0) begin
      send_header(len, $urandom_range(1, HEADER_BYTES - 1));
      send_item(FUNC_DISCONNECT, pick_byte());
      return;
    end

    send_header(len, HEADER_BYTES);
    case (phase_q)
      IN_BODY: begin
        n_body = pkt_len_q - HEADER_BYTES;
        if (n_body > BODY_CAP || $urandom_range(0, 19) == 0) begin
          n_send = $urandom_range(0, (n_body - 1 > BODY_CAP) ? BODY_CAP : n_body - 1);
          repeat (n_send) send_item(FUNC_BYTE, pick_byte());
          send_item(FUNC_DISCONNECT, pick_byte());
        end else begin
          repeat (n_body) send_item(FUNC_BYTE, pick_byte());
        end
      end
      DROPPING: begin
        repeat ($urandom_range(0, 3)) send_item(FUNC_BYTE, pick_byte());
        send_item(FUNC_DISCONNECT, pick_byte());
      end
      default: ;
    endcase
  endtask

  // header-only packet, one-byte body, oversize length then drop and reconnect
  task automatic test_directed();
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'h08);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_BYTE, 8'hA5);
    send_item(FUNC_BYTE, 8'h5A);
    send_header(32'd9, 4);
    repeat (5) send_item(FUNC_BYTE, 8'hFF);
    send_header(32'hFFFF_FFFF, 4);
    repeat (4) send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_DISCONNECT, 8'h00);
    wait_drained();
  endtask

  // random traffic under one length limit, with occasional full drains
  task automatic test_random_traffic(input logic [15:0] limit, input int n_items,
                                     input bit gaps);
    int start;
    write_max_len(limit);
    sender_gaps = gaps;
    start = items_sent;
    while (items_sent - start < n_items) begin
      send_random_packet();
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
    if ($urandom_range(0, 1) == 0) send_item(FUNC_DISCONNECT, pick_byte());
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  // hold the receiver off while a long packet streams in
  task automatic test_backpressure();
    write_max_len(16'd200);
    sender_gaps = 1'b0;
    hold_req = 300;
    send_header(32'd70, HEADER_BYTES);
    repeat (62) send_item(FUNC_BYTE, pick_byte());
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  initial begin
    max_len_q = MAX_LEN_RESET;
    deframe_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(MAX_LEN_RESET, 70, 1'b1);
    test_random_traffic(16'd8, 60, 1'b1);
    test_random_traffic(16'd0, 40, 1'b0);
    test_random_traffic(16'hFFFF, 80, 1'b1);
    test_backpressure();
    test_random_traffic(16'd12, 60, 1'b0);
    test_random_traffic(16'($urandom_range(9, 200)), 90, 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      mismatches++;
    end

    $display("covered %0d items, %0d words checked (%0d length errors)",
             items_sent, words_checked, errors_seen);
    $display("across %0d length limits, with bursts, stalls and a long hold-off",
             settings_used);
    if (mismatches == 0) begin
      $display("length_prefixed_packet_deframer_unit regression: pass");
    end else begin
      $display("length_prefixed_packet_deframer_unit regression: fail");
    end
    $finish;
  end

endmodule
